>>> hw/rtl/xlb_pkg.sv
`default_nettype none
package xlb_pkg;

	localparam int CMD_W   = 3;
	localparam int VALUE_W = 60;
	localparam int RANK_W  = 61;
	localparam int COUNT_W = 6;

	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SPAN   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MAX    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_MIN    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_KTH    = 3'd4;

	// row operation of the shared xor unit
	typedef enum logic [1:0] {
		OP_ELIM = 2'd0,
		OP_MAX  = 2'd1,
		OP_RED  = 2'd2,
		OP_SEL  = 2'd3
	} xlb_op_t;

	typedef struct packed {
		xlb_op_t op;
		logic    row_valid;
		logic    kbit;
		logic    first;
	} xlb_alu_ctl_t;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [VALUE_W-1:0] value;
		logic [RANK_W-1:0]  rank;
	} xlb_request_t;

	typedef struct packed {
		logic [VALUE_W-1:0] result_value;
		logic               success;
		logic [COUNT_W-1:0] basis_count;
	} xlb_result_t;

endpackage
`default_nettype wire

>>> hw/rtl/xor_linear_basis_engine.sv
// Channel  | Handshake                  | Payload
// ---------+----------------------------+------------------------------------
// request  | start & !busy -> transfer  | command, value, rank
// result   | done (one cycle)           | result_value, success, basis_count
//
// Insert, span test and max xor walk the pivot rows top down, one row per cycle through
// the single-port-read row RAM. Min nonzero and kth smallest walk the rows bottom up on a
// reduced basis; after reset or a successful insert they first reduce each pivot row
// above the bottom row in turn, skipping empty rows. Unknown commands raise done in the
// cycle after the transfer. Reset clears the row valid bits, the rank count and the
// reduced flag at once. done cannot be stalled.
`default_nettype none
module xor_linear_basis_engine #(
	parameter int VEC_BITS = 60
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output      logic                  busy,
	input  wire xlb_pkg::xlb_request_t request,
	output      logic                  done,
	output      xlb_pkg::xlb_result_t  result
);
	import xlb_pkg::*;

	localparam int AW    = $clog2(VEC_BITS);
	localparam int CNT_W = $clog2(VEC_BITS + 1);
	localparam logic [AW-1:0] LAST = AW'(VEC_BITS - 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_LOAD  = 4'b0010,
		S_SWEEP = 4'b0100,
		S_RNEXT = 4'b1000
	} state_t;

	state_t                 state_q;
	xlb_op_t                op_q;
	logic [CMD_W-1:0]       cmd_q;
	logic                   up_q;
	logic [VEC_BITS-1:0]    acc_q;
	logic [RANK_W-1:0]      km1_q;
	logic                   kzero_q;
	logic [AW-1:0]          idx_q;
	logic [AW-1:0]          jrow_q;
	logic [VEC_BITS-1:0]    valid_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   reduced_q;
	logic                   done_q;
	xlb_result_t            res_q;

	logic [AW-1:0]          idx_nxt;
	logic                   sweep_end;
	logic [AW-1:0]          rd_addr;
	logic [VEC_BITS-1:0]    rd_data;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	xlb_alu_ctl_t           alu_ctl;
	logic [VEC_BITS-1:0]    acc_n;
	logic                   stop;
	logic [RANK_W-1:0]      km1_n;
	logic                   kth_ok;

	assign idx_nxt   = up_q ? idx_q + AW'(1) : idx_q - AW'(1);
	assign sweep_end = up_q ? (idx_q == LAST) : (idx_q == '0);
	assign rd_addr   = (state_q == S_SWEEP) ? idx_nxt : idx_q;

	assign alu_ctl.op        = op_q;
	assign alu_ctl.row_valid = valid_q[idx_q];
	assign alu_ctl.kbit      = km1_q[0];
	assign alu_ctl.first     = (idx_q == jrow_q);

	xlb_row_alu #(.WIDTH(VEC_BITS)) u_alu (
		.ctl   (alu_ctl),
		.idx   (idx_q),
		.acc   (acc_q),
		.row   (rd_data),
		.acc_n (acc_n),
		.stop  (stop)
	);

	assign wr_en = (state_q == S_SWEEP) &&
		((op_q == OP_ELIM && cmd_q == CMD_INSERT && stop) || (op_q == OP_RED && sweep_end));
	assign wr_addr = (op_q == OP_RED) ? jrow_q : idx_q;

	xlb_ram #(.WIDTH(VEC_BITS), .DEPTH(VEC_BITS)) u_rows (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (acc_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// one rank bit is consumed per pivot row
	assign km1_n  = valid_q[idx_q] ? (km1_q >> 1) : km1_q;
	assign kth_ok = !kzero_q && (km1_n == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			cnt_q     <= '0;
			reduced_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= request.command;
						acc_q   <= VEC_BITS'(request.value);
						kzero_q <= (request.rank == '0);
						km1_q   <= (request.command == CMD_MIN) ? RANK_W'(1)
							: request.rank - RANK_W'(1);
						up_q    <= 1'b0;
						idx_q   <= LAST;
						case (request.command)
							CMD_INSERT, CMD_SPAN: begin
								op_q    <= OP_ELIM;
								state_q <= S_LOAD;
							end
							CMD_MAX: begin
								op_q    <= OP_MAX;
								state_q <= S_LOAD;
							end
							CMD_MIN, CMD_KTH: begin
								if (reduced_q) begin
									op_q    <= OP_SEL;
									up_q    <= 1'b1;
									idx_q   <= '0;
									acc_q   <= '0;
									state_q <= S_LOAD;
								end else begin
									op_q    <= OP_RED;
									jrow_q  <= '0;
									state_q <= S_RNEXT;
								end
							end
							default: begin
								res_q.result_value <= '0;
								res_q.success      <= 1'b1;
								res_q.basis_count  <= COUNT_W'(cnt_q);
								done_q             <= 1'b1;
							end
						endcase
					end
				end
				S_LOAD: begin
					state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					acc_q <= acc_n;
					idx_q <= idx_nxt;
					case (op_q)
						OP_ELIM: begin
							if (stop || sweep_end) begin
								state_q            <= S_IDLE;
								done_q             <= 1'b1;
								res_q.result_value <= '0;
								res_q.basis_count  <= COUNT_W'(cnt_q);
								if (cmd_q == CMD_INSERT) begin
									res_q.success <= stop;
									if (stop) begin
										valid_q[idx_q]    <= 1'b1;
										cnt_q             <= cnt_q + CNT_W'(1);
										reduced_q         <= 1'b0;
										res_q.basis_count <= COUNT_W'(cnt_q + CNT_W'(1));
									end
								end else begin
									res_q.success <= !stop;
								end
							end
						end
						OP_MAX: begin
							if (sweep_end) begin
								state_q            <= S_IDLE;
								done_q             <= 1'b1;
								res_q.result_value <= VALUE_W'(acc_n);
								res_q.success      <= 1'b1;
								res_q.basis_count  <= COUNT_W'(cnt_q);
							end
						end
						OP_RED: begin
							if (sweep_end) begin
								if (jrow_q == LAST) begin
									reduced_q <= 1'b1;
									op_q      <= OP_SEL;
									up_q      <= 1'b1;
									idx_q     <= '0;
									acc_q     <= '0;
									state_q   <= S_LOAD;
								end else begin
									jrow_q  <= jrow_q + AW'(1);
									state_q <= S_RNEXT;
								end
							end
						end
						OP_SEL: begin
							km1_q <= km1_n;
							if (sweep_end) begin
								state_q           <= S_IDLE;
								done_q            <= 1'b1;
								res_q.basis_count <= COUNT_W'(cnt_q);
								if (cmd_q == CMD_MIN) begin
									res_q.result_value <= VALUE_W'(acc_n);
									res_q.success      <= 1'b1;
								end else begin
									res_q.result_value <= kth_ok ? VALUE_W'(acc_n) : '0;
									res_q.success      <= kth_ok;
								end
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_RNEXT: begin
					// skip empty rows and the bottom row, which is already reduced
					if (valid_q[jrow_q] && jrow_q != '0) begin
						idx_q   <= jrow_q;
						up_q    <= 1'b0;
						state_q <= S_LOAD;
					end else if (jrow_q == LAST) begin
						reduced_q <= 1'b1;
						op_q      <= OP_SEL;
						up_q      <= 1'b1;
						idx_q     <= '0;
						acc_q     <= '0;
						state_q   <= S_LOAD;
					end else begin
						jrow_q <= jrow_q + AW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	a_count_matches_rows: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) == $countones(valid_q))
		else $error("rank count differs from number of pivot rows");

	a_done_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_insert_empty_row: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && op_q == OP_ELIM) |-> !valid_q[wr_addr])
		else $error("insert overwrites an occupied pivot row");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a transfer");

endmodule
`default_nettype wire

>>> hw/rtl/xlb_ram.sv
`default_nettype none
module xlb_ram #(
	parameter int WIDTH = 60,
	parameter int DEPTH = 60
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

>>> hw/rtl/xlb_row_alu.sv
`default_nettype none
module xlb_row_alu #(
	parameter int WIDTH = 60
) (
	input  wire xlb_pkg::xlb_alu_ctl_t         ctl,
	input  wire logic [$clog2(WIDTH)-1:0]      idx,
	input  wire logic [WIDTH-1:0]              acc,
	input  wire logic [WIDTH-1:0]              row,
	output      logic [WIDTH-1:0]              acc_n,
	output      logic                          stop
);
	import xlb_pkg::*;

	logic abit;

	assign abit = acc[idx];

	always_comb begin
		acc_n = acc;
		stop  = 1'b0;
		case (ctl.op)
			OP_ELIM: begin
				// leading bit with no pivot row: insert point, or not in span
				if (abit) begin
					if (ctl.row_valid) begin
						acc_n = acc ^ row;
					end else begin
						stop = 1'b1;
					end
				end
			end
			OP_MAX: begin
				if (ctl.row_valid && !abit) begin
					acc_n = acc ^ row;
				end
			end
			OP_RED: begin
				if (ctl.first) begin
					acc_n = row;
				end else if (ctl.row_valid && abit) begin
					acc_n = acc ^ row;
				end
			end
			OP_SEL: begin
				if (ctl.row_valid && ctl.kbit) begin
					acc_n = acc ^ row;
				end
			end
			default: begin
				acc_n = acc;
			end
		endcase
	end

endmodule
`default_nettype wire
